// ===== rtl/pss_pkg.sv =====
// package for the priority slot scheduler: widths, op codes, item structs,
// controller state and controller/datapath command and status structs
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned IdW = 4;
  localparam int unsigned TimeW = 63;
  localparam int unsigned PrioW = 8;
  localparam int unsigned DurW = 32;
  localparam logic [TimeW-1:0] TimeNone = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_PICK     = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [IdW-1:0]   slot_id;
    logic [TimeW-1:0] time_value;
    logic [PrioW-1:0] priority_req;
    logic [DurW-1:0]  duration;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IdW-1:0]   picked_slot;
    logic             wakeup_valid;
    logic [TimeW-1:0] wakeup_time;
    logic             accepted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_LIMIT,
    ST_SCAN2,
    ST_FINISH,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic simple;   // execute submit/cancel/complete
    logic clr_scan; // reset scan index and accumulators
    logic scan1;    // one step of the candidate scan
    logic limit;    // form now + duration of best
    logic scan2;    // one step of the collision scan
    logic finish;   // commit pick result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pick;
    logic last;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/pss_ctrl.sv =====
// controller state machine of the priority slot scheduler
// uses pss_pkg; drives the datapath by cmd_t, reads stat_t
`timescale 1ns / 1ps
`default_nettype none
module pss_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire pss_pkg::stat_t stat_i,
  output pss_pkg::cmd_t       cmd_o
);
  import pss_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN1;
      ST_SCAN1: begin
        if (!stat_i.is_pick) state_d = ST_OUT;
        else if (stat_i.last) state_d = ST_LIMIT;
      end
      ST_LIMIT:  state_d = ST_SCAN2;
      ST_SCAN2:  if (stat_i.last) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        cmd_o.clr_scan = in_valid_i;
      end
      ST_SCAN1: begin
        cmd_o.simple = !stat_i.is_pick;
        cmd_o.scan1 = stat_i.is_pick;
      end
      ST_LIMIT: begin
        cmd_o.limit = 1'b1;
        cmd_o.clr_scan = 1'b1;
      end
      ST_SCAN2:  cmd_o.scan2 = 1'b1;
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/pss_dp.sv =====
// datapath of the priority slot scheduler: slot tables, order matrix,
// one-slot-per-cycle scan unit and result register; uses pss_pkg
`timescale 1ns / 1ps
`default_nettype none
module pss_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pss_pkg::in_item_t in_data_i,
  input  wire pss_pkg::cmd_t     cmd_i,
  output pss_pkg::stat_t         stat_o,
  output pss_pkg::out_item_t     out_data_o
);
  import pss_pkg::*;

  localparam int unsigned IdxW = $clog2(Slots);

  logic [TimeW-1:0] due_q [Slots];
  logic [PrioW-1:0] prio_q [Slots];
  logic [DurW-1:0]  len_q [Slots];
  logic [Slots-1:0] queued_q;
  logic [Slots-1:0] before_q [Slots];
  logic [IdW:0]     mark_q;

  in_item_t         item_q;
  logic [IdxW-1:0]  idx_q;
  logic             best_v_q;
  logic [IdxW-1:0]  best_q;
  logic [TimeW-1:0] wake_q;
  logic             clash_q;
  logic [TimeW-1:0] clash_t_q;
  logic [TimeW:0]   limit_q;
  out_item_t        res_q;
  out_item_t        res_d;

  logic [IdxW-1:0]  id;
  logic             id_ok;
  logic             cur_q_b;
  logic             win;
  logic             enq;
  logic             deq;
  logic [IdxW-1:0]  upd_id;
  logic [TimeW-1:0] enq_time;

  assign id = item_q.slot_id[IdxW-1:0];
  assign id_ok = ({1'b0, item_q.slot_id} < (IdW+1)'(Slots));
  assign cur_q_b = queued_q[idx_q];
  assign stat_o.is_pick = (item_q.op == OP_PICK);
  assign stat_o.last = (idx_q == IdxW'(Slots-1));
  assign out_data_o = res_q;

  // candidate test: higher prio, or equal prio and earlier due time, then earlier in list order
  always_comb begin
    win = 1'b0;
    if (!best_v_q) win = 1'b1;
    else if (prio_q[idx_q] > prio_q[best_q]) win = 1'b1;
    else if (prio_q[idx_q] == prio_q[best_q]) begin
      if (due_q[idx_q] != due_q[best_q]) win = due_q[idx_q] < due_q[best_q];
      else win = before_q[best_q][idx_q];
    end
  end

  // queue updates for enqueue and dequeue
  always_comb begin
    enq = 1'b0;
    deq = 1'b0;
    upd_id = id;
    enq_time = item_q.time_value;
    if (cmd_i.simple && id_ok) begin
      case (item_q.op)
        OP_SUBMIT:   enq = !queued_q[id];
        OP_CANCEL:   deq = queued_q[id];
        OP_COMPLETE: enq = (item_q.time_value != '0) && !queued_q[id]
                           && (mark_q != {1'b1, item_q.slot_id});
        default: ;
      endcase
    end
    if (cmd_i.finish && best_v_q && !clash_q) begin
      deq = 1'b1;
      upd_id = best_q;
    end
  end

  // result of the current item
  always_comb begin
    res_d = '0;
    if (cmd_i.finish) begin
      if (best_v_q && !clash_q) begin
        res_d.found = 1'b1;
        res_d.picked_slot = IdW'(best_q);
      end else if (best_v_q && clash_q) begin
        if (clash_t_q != TimeNone) begin
          res_d.wakeup_valid = 1'b1;
          res_d.wakeup_time = clash_t_q;
        end
      end else if (wake_q != TimeNone) begin
        res_d.wakeup_valid = 1'b1;
        res_d.wakeup_time = wake_q;
      end
    end else begin
      res_d.accepted = enq || deq;
    end
  end

  // slot tables, written at most once per item
  always_ff @(posedge clk_i) begin
    if (enq) due_q[upd_id] <= enq_time;
    if (cmd_i.simple && id_ok && item_q.op == OP_SUBMIT && !queued_q[id]) begin
      prio_q[id] <= item_q.priority_req;
      len_q[id] <= item_q.duration;
    end
  end

  // queued mask, order matrix and cancel mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      mark_q <= '0;
      for (int k = 0; k < Slots; k++) before_q[k] <= '0;
    end else begin
      if (enq || deq) begin
        for (int k = 0; k < Slots; k++) begin
          if (IdxW'(k) == upd_id) begin
            before_q[k] <= enq ? (queued_q & ~(Slots'(1) << upd_id)) : '0;
          end else begin
            before_q[k][upd_id] <= 1'b0;
          end
        end
        queued_q[upd_id] <= enq;
      end
      if (cmd_i.simple && id_ok && item_q.op == OP_CANCEL && !queued_q[id])
        mark_q <= {1'b1, item_q.slot_id};
      if (deq && cmd_i.finish) mark_q <= '0;
    end
  end

  // item capture, scan and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.clr_scan) begin
      idx_q <= '0;
      clash_q <= 1'b0;
      clash_t_q <= TimeNone;
    end
    if (cmd_i.load) begin
      best_v_q <= 1'b0;
      best_q <= '0;
      wake_q <= TimeNone;
    end
    if (cmd_i.scan1) begin
      idx_q <= idx_q + 1'b1;
      if (cur_q_b) begin
        if (due_q[idx_q] > item_q.time_value) begin
          if (due_q[idx_q] < wake_q) wake_q <= due_q[idx_q];
        end else if (win) begin
          best_v_q <= 1'b1;
          best_q <= idx_q;
        end
      end
    end
    if (cmd_i.limit)
      limit_q <= {1'b0, item_q.time_value} + (TimeW+1)'(len_q[best_q]);
    if (cmd_i.scan2) begin
      idx_q <= idx_q + 1'b1;
      if (best_v_q && cur_q_b && idx_q != best_q && prio_q[idx_q] > prio_q[best_q]
          && {1'b0, due_q[idx_q]} < limit_q) begin
        clash_q <= 1'b1;
        if (due_q[idx_q] < clash_t_q) clash_t_q <= due_q[idx_q];
      end
    end
    if (cmd_i.simple || cmd_i.finish) res_q <= res_d;
  end
endmodule
`default_nettype wire

// ===== rtl/priority_slot_scheduler.sv =====
// top level of the priority slot scheduler: controller plus datapath
// uses pss_pkg, pss_ctrl, pss_dp
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. Submit, cancel and complete are executed in the
// state after the accepting edge, and their result is registered; pick
// runs two passes of the one-slot-per-cycle scan unit, a candidate pass
// and a collision pass, with a step to form the limit between them and
// one to commit at the end. The result holds until taken, and the next
// item is accepted in the cycle after.
module priority_slot_scheduler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pss_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pss_pkg::out_item_t      out_data_o
);
  import pss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  pss_dp u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .stat_o(stat), .out_data_o
  );
endmodule
`default_nettype wire
